[hw/rtl/dht11_pkg.sv]
// Types and constants for the single-wire sensor reader.
// Used by dht11_single_wire_reader; no other dependencies.
package dht11_pkg;

   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned DUR_W      = 16;

   // register indexes (byte address / 4)
   typedef enum logic [2:0] {
      REG_PRE_HIGH      = 3'd0,
      REG_START_LOW     = 3'd1,
      REG_RELEASE_HIGH  = 3'd2,
      REG_RESP_WAIT     = 3'd3,
      REG_RESP_HOLD     = 3'd4,
      REG_RESP_WINDOW   = 3'd5,
      REG_BIT_SAMPLE    = 3'd6,
      REG_EDGE_TIMEOUT  = 3'd7
   } reg_idx_type;

   localparam logic [DUR_W-1:0] RST_PRE_HIGH     = 16'd4000;
   localparam logic [DUR_W-1:0] RST_START_LOW    = 16'd18000;
   localparam logic [DUR_W-1:0] RST_RELEASE_HIGH = 16'd30;
   localparam logic [DUR_W-1:0] RST_RESP_WAIT    = 16'd40;
   localparam logic [DUR_W-1:0] RST_RESP_HOLD    = 16'd80;
   localparam logic [DUR_W-1:0] RST_RESP_WINDOW  = 16'd200;
   localparam logic [DUR_W-1:0] RST_BIT_SAMPLE   = 16'd40;
   localparam logic [DUR_W-1:0] RST_EDGE_TIMEOUT = 16'd120;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_START = 2'd1,
      OP_READ  = 2'd2,
      OP_RSVD  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_RESP_OK   = 2'd0,
      ST_RESP_FAIL = 2'd1,
      ST_BYTE_OK   = 2'd2,
      ST_BYTE_TMO  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_PRE_HIGH  = 4'd1,
      PH_START_LOW = 4'd2,
      PH_REL_HIGH  = 4'd3,
      PH_RESP_WAIT = 4'd4,
      PH_RESP_HOLD = 4'd5,
      PH_RESP_POLL = 4'd6,
      PH_BIT_RISE  = 4'd7,
      PH_BIT_DELAY = 4'd8,
      PH_BIT_FALL  = 4'd9
   } phase_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic       line_level;
   } req_type;

   typedef struct packed {
      logic       drive_enable;
      logic       drive_level;
      logic       busy_res;
      logic       done_res;
      logic [1:0] status;
      logic [7:0] data_byte;
   } rsp_type;

endpackage

[hw/rtl/dht11_single_wire_reader.sv]
// Single-wire sensor bus master, one transaction per microsecond tick.
// Depends on dht11_pkg (types, register indexes, reset values).
//
//   channel | dir | handshake                       | payload
//   req     | in  | req_valid / req_ready           | req_payload (opcode, line_level)
//   rsp     | out | rsp_valid / rsp_ready           | rsp_payload (drive, busy, done, status, byte)
//   csr     | in  | psel / penable / pwrite / pready| paddr, pwdata, prdata
//
// The phase walk for a tick is combinational from the sequencer state and the
// request into the result register.
// A new tick is accepted every cycle while the result register is empty or
// being drained; a stalled rsp_ready holds one result and stops req_ready.
// Synchronous active-high reset: phase idle, counters zero, registers to defaults.
module dht11_single_wire_reader #(
   parameter int unsigned BITS_PER_READ = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  dht11_pkg::req_type                 req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output dht11_pkg::rsp_type                 rsp_payload,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [dht11_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [dht11_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [dht11_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                               pready
);
   import dht11_pkg::*;

   localparam int unsigned BIDX_W = 3;
   localparam logic [BIDX_W:0] LAST_BIT = (BIDX_W+1)'(BITS_PER_READ);
   localparam int unsigned WALK_STEPS = 8;

   typedef struct packed {
      phase_type         phase;
      logic              cnt_zero;
      logic              incr;
      logic [BIDX_W-1:0] bidx;
      logic [7:0]        shift;
      rsp_type           rsp;
   } walk_type;

   // configuration registers
   logic [DUR_W-1:0] pre_high_ff, start_low_ff, release_high_ff, resp_wait_ff;
   logic [DUR_W-1:0] resp_hold_ff, resp_window_ff, bit_sample_ff, edge_timeout_ff;

   // sequencer state
   phase_type         phase_ff, phase_in;
   logic [DUR_W-1:0]  count_ff, count_in;
   logic [BIDX_W-1:0] bidx_ff, bidx_in;
   logic [7:0]        shift_ff, shift_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic             accept;
   logic             csr_wr;
   reg_idx_type      csr_idx;
   logic [DUR_W-1:0] dur_cur;
   logic             ge_cur;
   walk_type         walk;

   assign pready    = 1'b1;
   assign csr_wr    = psel && penable && pwrite && pready;
   assign csr_idx   = reg_idx_type'(paddr[CSR_ADDR_W-1:2]);
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_high_ff     <= RST_PRE_HIGH;
         start_low_ff    <= RST_START_LOW;
         release_high_ff <= RST_RELEASE_HIGH;
         resp_wait_ff    <= RST_RESP_WAIT;
         resp_hold_ff    <= RST_RESP_HOLD;
         resp_window_ff  <= RST_RESP_WINDOW;
         bit_sample_ff   <= RST_BIT_SAMPLE;
         edge_timeout_ff <= RST_EDGE_TIMEOUT;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_PRE_HIGH:     pre_high_ff     <= pwdata[DUR_W-1:0];
            REG_START_LOW:    start_low_ff    <= pwdata[DUR_W-1:0];
            REG_RELEASE_HIGH: release_high_ff <= pwdata[DUR_W-1:0];
            REG_RESP_WAIT:    resp_wait_ff    <= pwdata[DUR_W-1:0];
            REG_RESP_HOLD:    resp_hold_ff    <= pwdata[DUR_W-1:0];
            REG_RESP_WINDOW:  resp_window_ff  <= pwdata[DUR_W-1:0];
            REG_BIT_SAMPLE:   bit_sample_ff   <= pwdata[DUR_W-1:0];
            REG_EDGE_TIMEOUT: edge_timeout_ff <= pwdata[DUR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_PRE_HIGH:     prdata = CSR_DATA_W'(pre_high_ff);
         REG_START_LOW:    prdata = CSR_DATA_W'(start_low_ff);
         REG_RELEASE_HIGH: prdata = CSR_DATA_W'(release_high_ff);
         REG_RESP_WAIT:    prdata = CSR_DATA_W'(resp_wait_ff);
         REG_RESP_HOLD:    prdata = CSR_DATA_W'(resp_hold_ff);
         REG_RESP_WINDOW:  prdata = CSR_DATA_W'(resp_window_ff);
         REG_BIT_SAMPLE:   prdata = CSR_DATA_W'(bit_sample_ff);
         REG_EDGE_TIMEOUT: prdata = CSR_DATA_W'(edge_timeout_ff);
         default:          prdata = '0;
      endcase
   end

   // limit of the phase held at the start of the tick
   always_comb begin
      unique case (phase_ff)
         PH_PRE_HIGH:  dur_cur = pre_high_ff;
         PH_START_LOW: dur_cur = start_low_ff;
         PH_REL_HIGH:  dur_cur = release_high_ff;
         PH_RESP_WAIT: dur_cur = resp_wait_ff;
         PH_RESP_HOLD: dur_cur = resp_hold_ff;
         PH_RESP_POLL: dur_cur = resp_window_ff;
         PH_BIT_DELAY: dur_cur = bit_sample_ff;
         PH_BIT_RISE,
         PH_BIT_FALL:  dur_cur = edge_timeout_ff;
         default:      dur_cur = '0;
      endcase
   end
   assign ge_cur = count_ff >= dur_cur;

   // Walk the phases for one tick. Only the phase held at tick start has a
   // running count; any phase entered this tick starts at zero, so its limit
   // test reduces to "limit is zero". The chain is at most six phases long.
   always_comb begin
      walk_type   w;
      logic       line;
      logic       run;
      logic       expired;
      logic       edge_seen;
      logic       rise;
      line = req_payload.line_level;
      w          = '0;
      w.phase    = phase_ff;
      w.bidx     = bidx_ff;
      w.shift    = shift_ff;
      run        = 1'b1;
      expired    = 1'b0;
      edge_seen  = 1'b0;
      rise       = 1'b0;
      if (phase_ff == PH_IDLE) begin
         if (req_payload.opcode == OP_START) begin
            w.phase    = PH_PRE_HIGH;
            w.cnt_zero = 1'b1;
         end else if (req_payload.opcode == OP_READ) begin
            w.phase    = PH_BIT_RISE;
            w.cnt_zero = 1'b1;
            w.bidx     = '0;
            w.shift    = '0;
         end else begin
            run = 1'b0;
         end
      end
      for (int s = 0; s < WALK_STEPS; s++) begin
         if (run) begin
            unique case (w.phase)
               PH_PRE_HIGH:  expired = w.cnt_zero ? (pre_high_ff == '0) : ge_cur;
               PH_START_LOW: expired = w.cnt_zero ? (start_low_ff == '0) : ge_cur;
               PH_REL_HIGH:  expired = w.cnt_zero ? (release_high_ff == '0) : ge_cur;
               PH_RESP_WAIT: expired = w.cnt_zero ? (resp_wait_ff == '0) : ge_cur;
               PH_RESP_HOLD: expired = w.cnt_zero ? (resp_hold_ff == '0) : ge_cur;
               PH_RESP_POLL: expired = w.cnt_zero ? (resp_window_ff == '0) : ge_cur;
               PH_BIT_DELAY: expired = w.cnt_zero ? (bit_sample_ff == '0) : ge_cur;
               PH_BIT_RISE,
               PH_BIT_FALL:  expired = w.cnt_zero ? (edge_timeout_ff == '0) : ge_cur;
               default:      expired = 1'b1;
            endcase
            rise      = (w.phase == PH_BIT_RISE);
            edge_seen = !w.cnt_zero && (count_ff != '0) && (rise ? line : !line);
            unique case (w.phase)
               PH_PRE_HIGH, PH_START_LOW, PH_REL_HIGH: begin
                  if (expired) begin
                     w.phase    = phase_type'(w.phase + 4'd1);
                     w.cnt_zero = 1'b1;
                  end else begin
                     w.incr             = 1'b1;
                     w.rsp.drive_enable = 1'b1;
                     w.rsp.drive_level  = (w.phase != PH_START_LOW);
                     run                = 1'b0;
                  end
               end
               PH_RESP_WAIT: begin
                  if (expired) begin
                     w.phase    = line ? PH_RESP_POLL : PH_RESP_HOLD;
                     w.cnt_zero = 1'b1;
                  end else begin
                     w.incr = 1'b1;
                     run    = 1'b0;
                  end
               end
               PH_RESP_HOLD: begin
                  if (expired && line) begin
                     w.phase    = PH_RESP_POLL;
                     w.cnt_zero = 1'b1;
                  end else if (expired) begin
                     w.phase        = PH_IDLE;
                     w.cnt_zero     = 1'b1;
                     w.rsp.done_res = 1'b1;
                     w.rsp.status   = ST_RESP_FAIL;
                     run            = 1'b0;
                  end else begin
                     w.incr = 1'b1;
                     run    = 1'b0;
                  end
               end
               PH_RESP_POLL: begin
                  if (expired || !line) begin
                     w.phase        = PH_IDLE;
                     w.cnt_zero     = 1'b1;
                     w.rsp.done_res = 1'b1;
                     w.rsp.status   = expired ? ST_RESP_FAIL : ST_RESP_OK;
                  end else begin
                     w.incr = 1'b1;
                  end
                  run = 1'b0;
               end
               PH_BIT_RISE, PH_BIT_FALL: begin
                  if (edge_seen && rise) begin
                     w.phase    = PH_BIT_DELAY;
                     w.cnt_zero = 1'b1;
                  end else if (edge_seen && ({1'b0, w.bidx} + 4'd1 >= LAST_BIT)) begin
                     w.phase         = PH_IDLE;
                     w.cnt_zero      = 1'b1;
                     w.rsp.done_res  = 1'b1;
                     w.rsp.status    = ST_BYTE_OK;
                     w.rsp.data_byte = w.shift;
                     run             = 1'b0;
                  end else if (edge_seen) begin
                     w.bidx     = w.bidx + BIDX_W'(1);
                     w.phase    = PH_BIT_RISE;
                     w.cnt_zero = 1'b1;
                  end else if (expired) begin
                     w.phase        = PH_IDLE;
                     w.cnt_zero     = 1'b1;
                     w.rsp.done_res = 1'b1;
                     w.rsp.status   = ST_BYTE_TMO;
                     run            = 1'b0;
                  end else begin
                     w.incr = 1'b1;
                     run    = 1'b0;
                  end
               end
               PH_BIT_DELAY: begin
                  if (expired) begin
                     w.shift    = {w.shift[6:0], line};
                     w.phase    = PH_BIT_FALL;
                     w.cnt_zero = 1'b1;
                  end else begin
                     w.incr = 1'b1;
                     run    = 1'b0;
                  end
               end
               default: begin
                  w.phase    = PH_IDLE;
                  w.cnt_zero = 1'b1;
                  run        = 1'b0;
               end
            endcase
         end
      end
      w.rsp.busy_res = (w.phase != PH_IDLE);
      walk = w;
   end

   // next state
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      bidx_in  = bidx_ff;
      shift_in = shift_ff;
      if (accept) begin
         phase_in = walk.phase;
         bidx_in  = walk.bidx;
         shift_in = walk.shift;
         if (walk.incr) begin
            count_in = walk.cnt_zero ? DUR_W'(1) : count_ff + DUR_W'(1);
         end else if (walk.cnt_zero) begin
            count_in = '0;
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_in       = walk.rsp;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         count_ff     <= '0;
         bidx_ff      <= '0;
         shift_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         bidx_ff      <= bidx_in;
         shift_ff     <= shift_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted tick produced no result");

   a_done_ends_sequence: assert property (@(posedge clock) disable iff (reset)
      accept && walk.rsp.done_res |=> (phase_ff == PH_IDLE) && !rsp_ff.busy_res)
      else $error("sequence still running after done");

   a_status_only_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.done_res |-> (rsp_ff.status == ST_RESP_OK)
         && (rsp_ff.data_byte == 8'd0))
      else $error("status or data without done");

   a_drive_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.drive_enable |-> rsp_ff.busy_res && !rsp_ff.done_res)
      else $error("line driven outside a start sequence");

   a_idle_state_clean: assert property (@(posedge clock) disable iff (reset)
      accept && (phase_ff == PH_IDLE) && (req_payload.opcode == OP_TICK)
         |=> (phase_ff == PH_IDLE) && $stable(count_ff))
      else $error("idle tick changed sequencer state");

endmodule
